// ===== sv/tpe_pkg.sv =====
// shared types and constants of the threshold protection element
// depends on nothing; imported by tpe_scale and threshold_protection_element_core
package tpe_pkg;

	localparam int FIELD_W    = 32;
	localparam int NUM_VALUES = 10;
	localparam int IN_DATA_W  = 328;
	localparam int OUT_DATA_W = 8;
	localparam int LEVEL_W    = 34;
	localparam int SUM_W      = 33;
	localparam int WIDE_W     = 64;
	localparam int CNT_W      = 24;
	localparam int PCT_W      = 8;
	localparam int QUO_W      = 25;
	localparam int REM_W      = 7;
	localparam int RP_W       = 15;
	localparam int IDX_W      = 3;

	localparam logic [PCT_W-1:0] PERCENT_BASE   = 8'd100;
	localparam logic [PCT_W-1:0] RETURN_PCT_RST = 8'd95;

	// reciprocals of 100: exact for magnitudes up to 2^31, and for remainder products
	localparam logic [FIELD_W-1:0] RECIP_100          = 32'h51EB_851F;
	localparam int                 RECIP_SHIFT        = 37;
	localparam logic [15:0]        RECIP_100_NARROW   = 16'd41944;
	localparam int                 RECIP_NARROW_SHIFT = 22;

	typedef enum logic [IDX_W-1:0] {
		REG_ENABLE  = 3'd0,
		REG_UNDER   = 3'd1,
		REG_SELECT  = 3'd2,
		REG_LEVEL   = 3'd3,
		REG_PERCENT = 3'd4,
		REG_DELAY   = 3'd5
	} reg_index_t;

	// quantity selector codes
	localparam logic [3:0] SEL_PO   = 4'd4;
	localparam logic [3:0] SEL_QO   = 4'd5;
	localparam logic [3:0] SEL_PR   = 4'd7;
	localparam logic [3:0] SEL_QR   = 4'd8;
	localparam logic [3:0] SEL_LAST = 4'd9;

endpackage

// ===== sv/tpe_scale.sv =====
// return level unit: level * percent / 100, truncated toward zero
// magnitude split as 100*q + r by reciprocal multiply, then q*percent + r*percent/100,
// stepped through the RECIP, REM, PROD and FIN states; uses tpe_pkg
module tpe_scale (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [tpe_pkg::FIELD_W-1:0] level,
	input  logic        [tpe_pkg::PCT_W-1:0]   percent,
	output logic                               busy,
	output logic signed [tpe_pkg::LEVEL_W-1:0] scaled
);
	import tpe_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RECIP = 5'b00010,
		ST_REM   = 5'b00100,
		ST_PROD  = 5'b01000,
		ST_FIN   = 5'b10000
	} scale_state_t;

	scale_state_t              state_q;
	logic                      neg_q;
	logic [FIELD_W-1:0]        mag_q;
	logic [PCT_W-1:0]          pct_q;
	logic [QUO_W-1:0]          quo_q;
	logic [REM_W-1:0]          rem_q;
	logic [SUM_W-1:0]          hi_q;
	logic [RP_W-1:0]           rp_q;
	logic signed [LEVEL_W-1:0] scaled_q;

	logic [WIDE_W-1:0]  recip_prod;
	logic [FIELD_W-1:0] fine_prod;
	logic [SUM_W-1:0]   sum;
	logic [LEVEL_W-1:0] quot;

	always_comb begin
		recip_prod = WIDE_W'(mag_q) * WIDE_W'(RECIP_100);
		fine_prod  = FIELD_W'(rp_q) * FIELD_W'(RECIP_100_NARROW);
		sum        = hi_q + SUM_W'(fine_prod[RECIP_NARROW_SHIFT +: PCT_W]);
		quot       = {1'b0, sum};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scaled_q <= '0;
		end else if (start) begin
			state_q <= ST_RECIP;
		end else begin
			case (state_q)
				ST_RECIP: state_q <= ST_REM;
				ST_REM:   state_q <= ST_PROD;
				ST_PROD:  state_q <= ST_FIN;
				ST_FIN: begin
					state_q  <= ST_IDLE;
					scaled_q <= neg_q ? -$signed(quot) : $signed(quot);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= level[FIELD_W-1];
			mag_q <= level[FIELD_W-1] ? (FIELD_W'(0) - $unsigned(level)) : $unsigned(level);
			pct_q <= percent;
		end else begin
			case (state_q)
				ST_RECIP: quo_q <= recip_prod[RECIP_SHIFT +: QUO_W];
				ST_REM:   rem_q <= REM_W'(mag_q - FIELD_W'(quo_q) * FIELD_W'(PERCENT_BASE));
				ST_PROD: begin
					hi_q <= SUM_W'(quo_q) * SUM_W'(pct_q);
					rp_q <= RP_W'(rem_q) * RP_W'(pct_q);
				end
				default: ;
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign scaled = scaled_q;

endmodule

// ===== sv/threshold_protection_element_core.sv =====
// top level of the threshold protection element: stream ports, registers, compare and timer
// depends on tpe_pkg and tpe_scale
//
// One tick request in, one result out, one request per cycle sustained while m_tready is
// high and no recomputation runs. A taken request passes the input register, then the
// result register, which loads and raises m_tvalid when the input stage advances. A
// request holds an input stage while the result register still waits on m_tready. Each
// register write starts a recomputation of the return level (reciprocal multiply for the
// divide by 100, then the rescale, in tpe_scale); s_tready is low while recalc_q is set
// and while tpe_scale is busy. The value used is the low VALUE_WIDTH bits of the selected
// 32-bit field, sign extended.
module threshold_protection_element_core #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// zero_seq_current, zero_seq_voltage, neg_seq_current, neg_seq_voltage,
	// active_power_zero, reactive_power_zero, apparent_power_zero, active_power_neg,
	// reactive_power_neg, apparent_power_neg (32 bits each), blocked (bit 320), zero pad
	input  logic [tpe_pkg::IN_DATA_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// started (bit 0), tripped (bit 1), zero pad
	output logic [tpe_pkg::OUT_DATA_W-1:0]      m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tpe_pkg::IDX_W-1:0]           cfg_index,
	input  logic [tpe_pkg::FIELD_W-1:0]         cfg_data
);
	import tpe_pkg::*;

	// configuration
	logic                       enable_q;
	logic                       under_q;
	logic [3:0]                 sel_q;
	logic signed [FIELD_W-1:0]  level_q;
	logic [PCT_W-1:0]           percent_q;
	logic [CNT_W-1:0]           delay_q;
	logic                       recalc_q;

	logic                       scale_busy;
	logic signed [LEVEL_W-1:0]  scaled_level;

	// pipeline
	logic                           s1_valid_q;
	logic signed [VALUE_WIDTH-1:0]  val_s1;
	logic                           pq_s1;
	logic                           blk_s1;

	logic             m_valid_q;
	logic             started_q;
	logic             tripped_q;
	logic             pickup_q;
	logic [CNT_W-1:0] count_q;

	logic s_acc;
	logic adv;
	logic sel_ok;
	logic [8:0] sel_off;
	logic [VALUE_WIDTH-1:0] val_pick;

	logic signed [LEVEL_W-1:0] val_ext;
	logic signed [LEVEL_W-1:0] lvl;
	logic [LEVEL_W-1:0]        val_mag;
	logic [LEVEL_W-1:0]        lvl_mag;
	logic                      same_sign;
	logic                      cmp;
	logic                      start_now;
	logic                      trip_now;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			under_q   <= 1'b0;
			sel_q     <= '0;
			level_q   <= '0;
			percent_q <= RETURN_PCT_RST;
			delay_q   <= '0;
			recalc_q  <= 1'b0;
		end else begin
			recalc_q <= cfg_valid;
			if (cfg_valid) begin
				case (cfg_index)
					REG_ENABLE:  enable_q  <= cfg_data[0];
					REG_UNDER:   under_q   <= cfg_data[0];
					REG_SELECT:  sel_q     <= cfg_data[3:0];
					REG_LEVEL:   level_q   <= $signed(cfg_data);
					REG_PERCENT: percent_q <= cfg_data[PCT_W-1:0];
					REG_DELAY:   delay_q   <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
		end
	end

	tpe_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (recalc_q),
		.level   (level_q),
		.percent (percent_q),
		.busy    (scale_busy),
		.scaled  (scaled_level)
	);

	// handshake
	assign adv      = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !recalc_q && !scale_busy && (!s1_valid_q || adv);
	assign s_acc    = s_tvalid && s_tready;

	// quantity selection at the input register
	always_comb begin
		sel_ok   = sel_q <= SEL_LAST;
		sel_off  = {sel_q, 5'd0};
		val_pick = sel_ok ? s_tdata[sel_off +: VALUE_WIDTH] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			val_s1 <= $signed(val_pick);
			pq_s1  <= (sel_q == SEL_PO) || (sel_q == SEL_QO) ||
			          (sel_q == SEL_PR) || (sel_q == SEL_QR);
			blk_s1 <= s_tdata[NUM_VALUES*FIELD_W];
		end
	end

	// compare with hysteresis and sign check for the active and reactive power quantities
	always_comb begin
		val_ext   = LEVEL_W'(val_s1);
		lvl       = pickup_q ? scaled_level : LEVEL_W'(level_q);
		val_mag   = val_ext[LEVEL_W-1] ? (LEVEL_W'(0) - $unsigned(val_ext)) : $unsigned(val_ext);
		lvl_mag   = lvl[LEVEL_W-1] ? (LEVEL_W'(0) - $unsigned(lvl)) : $unsigned(lvl);
		same_sign = val_ext[LEVEL_W-1] == lvl[LEVEL_W-1];
		if (pq_s1) begin
			cmp = same_sign && (under_q ? (val_mag <= lvl_mag) : (val_mag >= lvl_mag));
		end else begin
			cmp = under_q ? (val_ext <= lvl) : (val_ext >= lvl);
		end
		start_now = enable_q && !blk_s1 && cmp;
		trip_now  = start_now && (count_q >= delay_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			started_q <= 1'b0;
			tripped_q <= 1'b0;
			pickup_q  <= 1'b0;
			count_q   <= '0;
		end else begin
			if (adv) begin
				m_valid_q <= 1'b1;
				started_q <= start_now;
				tripped_q <= trip_now;
				pickup_q  <= start_now;
				if (!start_now) begin
					count_q <= '0;
				end else if (count_q < delay_q) begin
					count_q <= count_q + 1'b1;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'd0, tripped_q, started_q};

endmodule
